// ----- hdl/ipc_pkg.sv -----
// ipc_pkg: constants and shared types for the integer property classifier.
// No dependencies; imported by every module in hdl.
package ipc_pkg;
	localparam int unsigned DATA_WIDTH_DEF = 32;
	localparam int unsigned FIELD_W = 32;

	typedef struct packed {
		logic busy;
		logic done;
	} ctl_t;
endpackage

// ----- hdl/ipc_divider.sv -----
// ipc_divider: bit-serial restoring divider, one quotient bit per cycle.
// Depends on ipc_pkg.
module ipc_divider
	import ipc_pkg::*;
#(
	parameter int unsigned W = DATA_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output ctl_t         ctl,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	assign trial = {rem_q[W-1:0], quo_q[W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign ctl       = '{busy: busy_q, done: done_q};
	assign quotient  = quo_q;
	assign remainder = rem_q[W-1:0];
endmodule

// ----- hdl/ipc_root.sv -----
// ipc_root: digit-by-digit integer square root, two radicand bits per cycle.
// Depends on ipc_pkg.
module ipc_root
	import ipc_pkg::*;
#(
	parameter int unsigned W = DATA_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] radicand,
	output ctl_t         ctl,
	output logic [W-1:0] root,
	output logic         exact
);
	localparam int unsigned HW = (W + 1) / 2;
	localparam int unsigned RW = 2 * HW;
	localparam int unsigned CW = $clog2(HW + 1);

	logic [RW-1:0]  src_q;
	logic [HW+1:0]  rem_q;
	logic [HW-1:0]  res_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [HW+1:0]  trial;
	logic [HW+1:0]  tsub;
	logic [HW+1:0]  diff;

	assign trial = {rem_q[HW-1:0], src_q[RW-1 -: 2]};
	assign tsub  = {res_q, 2'b01};
	assign diff  = trial - tsub;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(HW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			src_q <= RW'(radicand);
			rem_q <= '0;
			res_q <= '0;
		end else if (busy_q) begin
			src_q <= {src_q[RW-3:0], 2'b00};
			if (trial >= tsub) begin
				rem_q <= diff;
				res_q <= {res_q[HW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				res_q <= {res_q[HW-2:0], 1'b0};
			end
		end
	end

	assign ctl   = '{busy: busy_q, done: done_q};
	assign root  = W'(res_q);
	assign exact = (rem_q == '0);
endmodule

// ----- hdl/integer_property_classifier.sv -----
// integer_property_classifier: top level, sequencer around a serial root and divider.
// Depends on ipc_pkg, ipc_root, ipc_divider.
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | value
//  out     | out_valid | out_stall | value_echo, is_odd .. is_perfect
//
// One word at a time. Sequence: one root, then digit reversal by repeated division by ten
// with the divider, then trial division by d = 2..root, also with the divider.
// The result register frees in_stall as soon as out is taken; a stalled result holds.
// Reset clears the sequencer and out_valid.
module integer_property_classifier
	import ipc_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [FIELD_W-1:0]   value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [FIELD_W-1:0]   value_echo,
	output logic                        is_odd,
	output logic                        is_even,
	output logic                        is_palindrome,
	output logic                        is_prime,
	output logic                        is_square,
	output logic                        is_perfect
);
	localparam int unsigned W  = DATA_WIDTH;
	localparam int unsigned MW = W + 1;
	localparam int unsigned AW = W + 4;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_ROOT = 7'b0000010,
		S_REV  = 7'b0000100,
		S_REVW = 7'b0001000,
		S_DIV  = 7'b0010000,
		S_DIVW = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [W-1:0]      raw_q;
	logic              neg_q;
	logic [MW-1:0]     mag_q;
	logic [MW-1:0]     t_q;
	logic [AW-1:0]     rev_q;
	logic              rev_ovf_q;
	logic [MW-1:0]     r_q;
	logic [MW-1:0]     d_q;
	logic [AW-1:0]     sum_q;
	logic              sq_q;
	logic              div_hit_q;

	logic              root_start;
	ctl_t              root_ctl;
	logic [MW-1:0]     root_res;
	logic              root_exact;
	logic              div_start;
	ctl_t              div_ctl;
	logic [MW-1:0]     div_dvd;
	logic [MW-1:0]     div_dsr;
	logic [MW-1:0]     div_quo;
	logic [MW-1:0]     div_rem;
	logic [AW-1:0]     rev_next;
	logic [MW-1:0]     mag_in;
	logic              take_in;
	logic              take_out;
	logic              pos_ge2;

	ipc_root #(.W(MW)) u_root (
		.clk(clk), .arst_n(arst_n), .start(root_start), .radicand(mag_q),
		.ctl(root_ctl), .root(root_res), .exact(root_exact)
	);

	ipc_divider #(.W(MW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(div_dsr), .ctl(div_ctl), .quotient(div_quo), .remainder(div_rem)
	);

	assign mag_in   = value[W-1] ? MW'(-{1'b1, value[W-1:0]}) : MW'(value[W-1:0]);
	assign take_in  = in_valid && !in_stall;
	assign take_out = out_valid && !out_stall;
	assign in_stall = (state_q != S_IDLE) || (out_valid && out_stall);
	assign pos_ge2  = !neg_q && (mag_q >= MW'(2));
	assign root_start = (state_q == S_ROOT) && !root_ctl.busy && !root_ctl.done;
	assign div_start  = (state_q == S_REV) ||
		((state_q == S_DIV) && pos_ge2 && (d_q <= r_q));
	assign div_dvd    = (state_q == S_REV) ? t_q : mag_q;
	assign div_dsr    = (state_q == S_REV) ? MW'(10) : d_q;
	assign rev_next   = (rev_q << 3) + (rev_q << 1) + AW'(div_rem);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (take_out)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (take_in) begin
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (root_ctl.done)
						state_q <= (t_q == '0) ? S_DIV : S_REV;
				end
				S_REV:  state_q <= S_REVW;
				S_REVW: if (div_ctl.done)
					state_q <= (div_quo == '0) ? S_DIV : S_REV;
				S_DIV: begin
					if (!pos_ge2 || d_q > r_q)
						state_q <= S_DONE;
					else
						state_q <= S_DIVW;
				end
				S_DIVW: if (div_ctl.done)
					state_q <= S_DIV;
				S_DONE: begin
					state_q   <= S_IDLE;
					out_valid <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (take_in) begin
				raw_q     <= value[W-1:0];
				neg_q     <= value[W-1];
				mag_q     <= mag_in;
				t_q       <= mag_in;
				rev_q     <= '0;
				rev_ovf_q <= 1'b0;
				d_q       <= MW'(2);
				sum_q     <= AW'(1);
				div_hit_q <= 1'b0;
			end
			S_ROOT: if (root_ctl.done) begin
				r_q  <= root_res;
				sq_q <= root_exact && !neg_q;
			end
			S_REVW: if (div_ctl.done) begin
				t_q   <= div_quo;
				rev_q <= rev_next;
				if (rev_next > AW'(mag_q) || rev_q[AW-1 -: 4] != '0)
					rev_ovf_q <= 1'b1;
			end
			S_DIVW: if (div_ctl.done) begin
				if (div_rem == '0) begin
					div_hit_q <= 1'b1;
					sum_q <= sum_q + AW'(d_q) + ((div_quo != d_q) ? AW'(div_quo) : '0);
				end
				d_q <= d_q + 1'b1;
			end
			S_DONE: begin
				value_echo    <= FIELD_W'($signed(raw_q));
				is_odd        <= !neg_q && mag_q[0];
				is_even       <= !mag_q[0];
				is_palindrome <= !rev_ovf_q && (rev_q == AW'(mag_q));
				is_prime      <= pos_ge2 && !div_hit_q;
				is_square     <= sq_q;
				is_perfect    <= pos_ge2 && (sum_q == AW'(mag_q));
			end
			default: ;
		endcase
	end

	ast_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input taken while busy");
	ast_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(value_echo)))
		else $error("result dropped under stall");
	ast_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(root_ctl.busy && div_ctl.busy))
		else $error("root and divider busy together");
	ast_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> out_valid)
		else $error("finished word not presented");
endmodule
